>>> design/owb_pkg.sv
// Shared types and constants of the one-wire bus master.
package owb_pkg;

  // Command codes carried in req_type.
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_RESET = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // Configuration register indexes.
  localparam int unsigned NUM_REGS = 8;
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [2:0] REG_SLOT_LOW      = 3'd3;
  localparam logic [2:0] REG_WRITE_RELEASE = 3'd4;
  localparam logic [2:0] REG_WRITE_TAIL    = 3'd5;
  localparam logic [2:0] REG_READ_SAMPLE   = 3'd6;
  localparam logic [2:0] REG_READ_TAIL     = 3'd7;

  localparam int unsigned CFG_WIDTH = 10;

  // Reset values, register 0 in the lowest slice.
  localparam logic [NUM_REGS-1:0][CFG_WIDTH-1:0] CFG_RESET = {
    10'd55, 10'd9, 10'd54, 10'd10, 10'd6, 10'd410, 10'd70, 10'd480
  };

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       line_level;
  } owb_in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_byte;
  } owb_out_t;

endpackage

>>> design/one_wire_bus_master.sv
// One-wire bus master top level: slot timing state machine and result register.
//
// Every input transaction is one microsecond tick: it carries the sampled bus
// level and an optional command (reset with presence detect, byte write or
// byte read). Each tick produces exactly one result transaction with the
// open-drain drive, busy, done, the presence flag and the last byte read.
// The block takes one tick per cycle unless stalled, and the result appears in the
// output register in the cycle after the tick is accepted. The whole timing
// state machine, including any run of zero-length phases that end within the
// same tick, is evaluated combinationally between the input port and the
// result register. The input stalls only while a result sits in the output
// register and the downstream side stalls it. Configuration writes are taken
// in every cycle (ready is tied high) and must only be issued while the bus
// master is idle. Commands arriving while an operation runs are ignored.
module one_wire_bus_master #(
  parameter int unsigned TIME_WIDTH = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  owb_pkg::owb_in_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output owb_pkg::owb_out_t   out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [9:0]          cfg_data_i
);
  import owb_pkg::*;

  localparam int unsigned TW = TIME_WIDTH;
  localparam logic [31:0] TIME_MAX = (32'd1 << TIME_WIDTH) - 32'd1;
  localparam int unsigned SETTLE_STEPS = 4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_TAIL,
    PH_SLOT_LOW,
    PH_HOLD_LOW,
    PH_RELEASE,
    PH_TAIL
  } phase_e;

  typedef struct packed {
    phase_e        phase;
    logic [1:0]    op;
    logic [TW-1:0] time_left;
    logic [2:0]    bit_count;
    logic [7:0]    shift_byte;
    logic          presence;
    logic [7:0]    read_result;
    logic          done;
  } owb_state_t;

  typedef logic [NUM_REGS-1:0][TW-1:0] owb_loads_t;

  // Register values clipped to the timer width.
  function automatic logic [TW-1:0] clip_time(logic [CFG_WIDTH-1:0] v);
    logic [31:0] vw;
    vw = 32'(v);
    if (vw > TIME_MAX) begin
      return '1;
    end
    return vw[TW-1:0];
  endfunction

  // One transition out of a phase whose time has run out. A slot whose phases
  // are all zero long is finished at once, so when the next slot is such a
  // slot the rest of the byte completes in this step.
  function automatic owb_state_t settle_step(owb_state_t s, owb_loads_t ld,
                                             logic lvl, logic fast_wr,
                                             logic fast_rd);
    owb_state_t r;
    logic       is_read;
    logic [7:0] sb;
    logic [2:0] rem;
    r       = s;
    is_read = (s.op == REQ_READ);
    sb      = is_read ? s.shift_byte : {1'b0, s.shift_byte[7:1]};
    rem     = 3'd7 - s.bit_count;
    if (s.phase != PH_IDLE && s.time_left == '0) begin
      unique case (s.phase)
        PH_RST_LOW: begin
          r.phase     = PH_RST_WAIT;
          r.time_left = ld[REG_PRESENCE_WAIT];
        end
        PH_RST_WAIT: begin
          r.presence  = ~lvl;
          r.phase     = PH_RST_TAIL;
          r.time_left = ld[REG_RESET_TAIL];
        end
        PH_RST_TAIL: begin
          r.phase = PH_IDLE;
          r.op    = REQ_TICK;
          r.done  = 1'b1;
        end
        PH_SLOT_LOW: begin
          if (is_read) begin
            r.phase     = PH_RELEASE;
            r.time_left = ld[REG_READ_SAMPLE];
          end else if (s.shift_byte[0]) begin
            r.phase     = PH_RELEASE;
            r.time_left = ld[REG_WRITE_RELEASE];
          end else begin
            r.phase     = PH_HOLD_LOW;
            r.time_left = ld[REG_WRITE_TAIL];
          end
        end
        PH_HOLD_LOW: begin
          r.phase     = PH_TAIL;
          r.time_left = ld[REG_WRITE_RELEASE];
        end
        PH_RELEASE: begin
          r.phase = PH_TAIL;
          if (is_read) begin
            r.shift_byte = {lvl, s.shift_byte[7:1]};
            r.time_left  = ld[REG_READ_TAIL];
          end else begin
            r.time_left  = ld[REG_WRITE_TAIL];
          end
        end
        PH_TAIL: begin
          r.shift_byte = sb;
          if (s.bit_count == 3'd7) begin
            if (is_read) begin
              r.read_result = sb;
            end
            r.bit_count = '0;
            r.phase     = PH_IDLE;
            r.op        = REQ_TICK;
            r.done      = 1'b1;
          end else if (is_read ? fast_rd : fast_wr) begin
            // Remaining slots take no time: read bits all see this level.
            if (is_read) begin
              r.read_result = (sb >> rem) | (lvl ? ~(8'hFF >> rem) : 8'h00);
              r.shift_byte  = r.read_result;
            end else begin
              r.shift_byte  = '0;
            end
            r.bit_count = '0;
            r.phase     = PH_IDLE;
            r.op        = REQ_TICK;
            r.done      = 1'b1;
          end else begin
            r.bit_count = s.bit_count + 3'd1;
            r.phase     = PH_SLOT_LOW;
            r.time_left = ld[REG_SLOT_LOW];
          end
        end
        default: begin
          r = s;
        end
      endcase
    end
    return r;
  endfunction

  function automatic owb_state_t settle(owb_state_t s, owb_loads_t ld, logic lvl,
                                        logic fast_wr, logic fast_rd);
    owb_state_t r;
    r = s;
    for (int k = 0; k < SETTLE_STEPS; k++) begin
      r = settle_step(r, ld, lvl, fast_wr, fast_rd);
    end
    return r;
  endfunction

  logic [NUM_REGS-1:0][CFG_WIDTH-1:0] cfg_q;
  owb_loads_t                         loads;
  logic                               fast_wr, fast_rd;

  phase_e        phase_q;
  logic [1:0]    op_q;
  logic [TW-1:0] time_left_q;
  logic [2:0]    bit_count_q;
  logic [7:0]    shift_byte_q;
  logic          presence_q;
  logic [7:0]    read_result_q;

  owb_state_t st_cur, st_acc, st_first, st_dec, st_d;
  logic       drive_d;
  logic       busy_d;
  logic       in_accept;

  owb_out_t   out_q;
  logic       out_valid_q;

  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      loads[i] = clip_time(cfg_q[i]);
    end
  end

  // A slot is zero long as a whole when every one of its phases is; for a
  // write this does not depend on the bit value.
  assign fast_wr = (loads[REG_SLOT_LOW] == '0) && (loads[REG_WRITE_RELEASE] == '0) &&
                   (loads[REG_WRITE_TAIL] == '0);
  assign fast_rd = (loads[REG_SLOT_LOW] == '0) && (loads[REG_READ_SAMPLE] == '0) &&
                   (loads[REG_READ_TAIL] == '0);

  // Per-tick next state: start a command on an idle tick, close any phases
  // that are zero long, count this tick down, then close phases that end now.
  always_comb begin
    st_cur.phase       = phase_q;
    st_cur.op          = op_q;
    st_cur.time_left   = time_left_q;
    st_cur.bit_count   = bit_count_q;
    st_cur.shift_byte  = shift_byte_q;
    st_cur.presence    = presence_q;
    st_cur.read_result = read_result_q;
    st_cur.done        = 1'b0;

    st_acc = st_cur;
    if (phase_q == PH_IDLE && in_data_i.req_type != REQ_TICK) begin
      st_acc.op        = in_data_i.req_type;
      st_acc.bit_count = '0;
      if (in_data_i.req_type == REQ_RESET) begin
        st_acc.phase     = PH_RST_LOW;
        st_acc.time_left = loads[REG_RESET_LOW];
      end else begin
        st_acc.shift_byte = (in_data_i.req_type == REQ_WRITE) ? in_data_i.data_byte : 8'h00;
        st_acc.phase      = PH_SLOT_LOW;
        st_acc.time_left  = loads[REG_SLOT_LOW];
      end
      st_first = settle(st_acc, loads, in_data_i.line_level, fast_wr, fast_rd);
    end else begin
      st_first = st_acc;
    end

    busy_d  = (st_first.phase != PH_IDLE);
    drive_d = (st_first.phase == PH_RST_LOW) || (st_first.phase == PH_SLOT_LOW) ||
              (st_first.phase == PH_HOLD_LOW);

    st_dec = st_first;
    if (busy_d) begin
      st_dec.time_left = st_first.time_left - TW'(1);
      st_d = settle(st_dec, loads, in_data_i.line_level, fast_wr, fast_rd);
    end else begin
      st_d = st_dec;
    end
  end

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q         <= CFG_RESET;
      phase_q       <= PH_IDLE;
      op_q          <= REQ_TICK;
      time_left_q   <= '0;
      bit_count_q   <= '0;
      shift_byte_q  <= '0;
      presence_q    <= 1'b0;
      read_result_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q[cfg_index_i] <= cfg_data_i;
      end
      if (in_accept) begin
        phase_q       <= st_d.phase;
        op_q          <= st_d.op;
        time_left_q   <= st_d.time_left;
        bit_count_q   <= st_d.bit_count;
        shift_byte_q  <= st_d.shift_byte;
        presence_q    <= st_d.presence;
        read_result_q <= st_d.read_result;
        out_valid_q   <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q.drive_low <= drive_d;
      out_q.busy_res  <= busy_d;
      out_q.done_res  <= st_first.done | st_d.done;
      out_q.presence  <= st_d.presence;
      out_q.read_byte <= st_d.read_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> design/owb_checker.sv
// Port-level checks of the one-wire bus master and their binding.
module owb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input owb_pkg::owb_out_t out_data_o
);
  import owb_pkg::*;

  // A stalled result stays in place unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  // No new tick may enter while a result is held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while output stalled");

  // With the result register empty there is nothing to hold the input back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output empty");

  // The bus is only pulled low by a running operation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.drive_low) |-> out_data_o.busy_res)
    else $error("drive low while not busy");

endmodule

bind one_wire_bus_master owb_checker u_owb_checker (.*);

>>> test/tb_top.sv
// Self-checking testbench of the one-wire bus master: directed table, then random phases.
`timescale 1ns / 100ps

module tb_top;
  import owb_pkg::*;

  // Register programming styles. KEEP leaves the registers as they are.
  localparam logic [3:0] CFG_KEEP    = 4'd0;
  localparam logic [3:0] CFG_ZERO    = 4'd2;
  localparam logic [3:0] CFG_ONE     = 4'd3;
  localparam logic [3:0] CFG_BITS    = 4'd4;
  localparam logic [3:0] CFG_SMALL   = 4'd5;
  localparam logic [3:0] CFG_MID     = 4'd6;

  // Traffic shapes of the two channels.
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  // Extra pressure applied halfway through a random phase.
  localparam int PRESS_NONE  = 0;
  localparam int PRESS_HOLD  = 1;
  localparam int PRESS_PAUSE = 2;

  localparam int HOLD_CYCLES = 200;

  // Phases of the slot timing machine as the testbench tracks them.
  typedef enum logic [2:0] {
    ST_IDLE, ST_RST_LOW, ST_RST_WAIT, ST_RST_TAIL,
    ST_SLOT_LOW, ST_HOLD_LOW, ST_RELEASE, ST_TAIL
  } bus_phase_e;

  // One row of the directed table: optional reprogramming before the tick, the tick
  // itself, and a hand-written result where the value is obvious.
  typedef struct packed {
    logic [3:0] setup;
    owb_in_t    item;
    logic       typed;
    owb_out_t   want;
  } dir_row_t;

  localparam int DIR_ROWS_N = 15;
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    // Straight out of reset: everything low, nothing read yet.
    '{CFG_KEEP,  '{REQ_TICK,  8'h00, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
    // All durations zero: every operation finishes on the tick that starts it.
    '{CFG_ZERO,  '{REQ_TICK,  8'hFF, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
    '{CFG_KEEP,  '{REQ_RESET, 8'h00, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b1, 8'h00}},
    '{CFG_KEEP,  '{REQ_RESET, 8'hFF, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00}},
    '{CFG_KEEP,  '{REQ_READ,  8'h00, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'hFF}},
    '{CFG_KEEP,  '{REQ_READ,  8'hFF, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00}},
    '{CFG_KEEP,  '{REQ_WRITE, 8'hFF, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00}},
    '{CFG_KEEP,  '{REQ_WRITE, 8'h00, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00}},
    '{CFG_KEEP,  '{REQ_RESET, 8'h5A, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b1, 8'h00}},
    '{CFG_KEEP,  '{REQ_READ,  8'hA5, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b1, 8'hFF}},
    '{CFG_KEEP,  '{REQ_TICK,  8'hAA, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'hFF}},
    // One tick per phase: a reset spans three ticks, and the commands that arrive
    // while it runs must be dropped.
    '{CFG_ONE,   '{REQ_RESET, 8'h00, 1'b1}, 1'b0, '0},
    '{CFG_KEEP,  '{REQ_WRITE, 8'h55, 1'b0}, 1'b0, '0},
    '{CFG_KEEP,  '{REQ_READ,  8'h0F, 1'b1}, 1'b0, '0},
    '{CFG_KEEP,  '{REQ_WRITE, 8'hA5, 1'b1}, 1'b0, '0}
  };

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  owb_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  owb_out_t out_data_o;
  logic     cfg_valid_i;
  logic     cfg_ready_o;
  logic [2:0] cfg_index_i;
  logic [9:0] cfg_data_i;

  // Shadow of the bus master: registers and timing state.
  logic [9:0] cfg_q [NUM_REGS];
  bus_phase_e ph;
  logic [1:0] op;
  logic [9:0] tick_cnt;
  logic [2:0] bit_idx;
  logic [7:0] shreg;
  logic       pres_q;
  logic [7:0] rd_q;

  // Results still owed by the block, oldest first.
  owb_out_t pending_outputs [$];

  // Hand-written result for the tick on offer, if any.
  bit       row_typed = 1'b0;
  owb_out_t row_want  = '0;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  int err_cnt        = 0;
  int ticks_taken    = 0;
  int ops_finished   = 0;
  int stalled_cycles = 0;
  int cfg_writes     = 0;

  one_wire_bus_master i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Walks through every phase that has run down to zero. A presence or read sample
  // takes the level of the tick on which its wait phase ends. Returns 1 when the
  // operation is over.
  function automatic bit advance_zero_phases(input logic lvl);
    while (ph != ST_IDLE && tick_cnt == '0) begin
      case (ph)
        ST_RST_LOW: begin
          ph = ST_RST_WAIT;
          tick_cnt = cfg_q[REG_PRESENCE_WAIT];
        end
        ST_RST_WAIT: begin
          // A device answering the reset pulls the line low.
          pres_q = ~lvl;
          ph = ST_RST_TAIL;
          tick_cnt = cfg_q[REG_RESET_TAIL];
        end
        ST_RST_TAIL: begin
          ph = ST_IDLE;
          op = REQ_TICK;
          return 1'b1;
        end
        ST_SLOT_LOW: begin
          if (op == REQ_READ) begin
            ph = ST_RELEASE;
            tick_cnt = cfg_q[REG_READ_SAMPLE];
          end else if (shreg[0]) begin
            ph = ST_RELEASE;
            tick_cnt = cfg_q[REG_WRITE_RELEASE];
          end else begin
            // A zero bit keeps the line low through the tail time.
            ph = ST_HOLD_LOW;
            tick_cnt = cfg_q[REG_WRITE_TAIL];
          end
        end
        ST_HOLD_LOW: begin
          ph = ST_TAIL;
          tick_cnt = cfg_q[REG_WRITE_RELEASE];
        end
        ST_RELEASE: begin
          ph = ST_TAIL;
          if (op == REQ_READ) begin
            // Bits arrive LSB first, so each one enters at the top.
            shreg = {lvl, shreg[7:1]};
            tick_cnt = cfg_q[REG_READ_TAIL];
          end else begin
            tick_cnt = cfg_q[REG_WRITE_TAIL];
          end
        end
        default: begin
          if (op != REQ_READ) shreg = shreg >> 1;
          if (bit_idx == 3'd7) begin
            if (op == REQ_READ) rd_q = shreg;
            bit_idx = '0;
            ph = ST_IDLE;
            op = REQ_TICK;
            return 1'b1;
          end
          bit_idx = bit_idx + 3'd1;
          ph = ST_SLOT_LOW;
          tick_cnt = cfg_q[REG_SLOT_LOW];
        end
      endcase
    end
    return 1'b0;
  endfunction

  // Advances the shadow by one microsecond tick and returns what the block must report.
  function automatic owb_out_t next_bus_outputs(input owb_in_t t);
    owb_out_t r;
    r = '0;
    // A command only starts from idle, and its accept tick is its first tick.
    if (ph == ST_IDLE && t.req_type != REQ_TICK) begin
      op = t.req_type;
      bit_idx = '0;
      if (t.req_type == REQ_RESET) begin
        ph = ST_RST_LOW;
        tick_cnt = cfg_q[REG_RESET_LOW];
      end else begin
        shreg = (t.req_type == REQ_WRITE) ? t.data_byte : 8'h00;
        ph = ST_SLOT_LOW;
        tick_cnt = cfg_q[REG_SLOT_LOW];
      end
      if (advance_zero_phases(t.line_level)) r.done_res = 1'b1;
    end
    if (ph != ST_IDLE) begin
      r.busy_res = 1'b1;
      r.drive_low = (ph == ST_RST_LOW || ph == ST_SLOT_LOW || ph == ST_HOLD_LOW);
      tick_cnt = tick_cnt - 10'd1;
      if (advance_zero_phases(t.line_level)) r.done_res = 1'b1;
    end
    r.presence = pres_q;
    r.read_byte = rd_q;
    return r;
  endfunction

  function automatic logic [1:0] random_command();
    case ($urandom_range(2))
      0: return REQ_RESET;
      1: return REQ_WRITE;
      default: return REQ_READ;
    endcase
  endfunction

  // Output check first, then the input transaction of the same edge: a result can
  // never belong to a tick that is accepted on the edge it shows up.
  always @(posedge clk_i) begin
    owb_out_t want;
    owb_out_t model;
    if (out_valid_o && !out_stall_i) begin
      if (pending_outputs.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, got %p", $time, out_data_o);
      end else begin
        want = pending_outputs.pop_front();
        if (out_data_o.drive_low !== want.drive_low || out_data_o.busy_res !== want.busy_res ||
            out_data_o.done_res !== want.done_res || out_data_o.presence !== want.presence ||
            out_data_o.read_byte !== want.read_byte) begin
          err_cnt++;
          $display("%0t: result mismatch, expected %p, got %p", $time, want, out_data_o);
        end
      end
    end
    if (in_valid_i && in_stall_o) stalled_cycles++;
    if (in_valid_i && !in_stall_o) begin
      model = next_bus_outputs(in_data_i);
      if (model.done_res) ops_finished++;
      ticks_taken++;
      pending_outputs.push_back(row_typed ? row_want : model);
    end
  end

  // Result side: random stalls per traffic shape, or a long hold when one is requested.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Offers one tick, with random idle cycles ahead of it, and returns at the falling
  // edge after the transaction has gone through.
  task automatic send_tick(input owb_in_t t, input bit typed, input owb_out_t want);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    row_typed = typed;
    row_want = want;
    in_valid_i <= 1'b1;
    in_data_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Stops offering ticks and waits until every owed result has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Writes all registers in one burst. Only called while the master is idle.
  task automatic program_regs(input logic [3:0] style);
    logic [9:0] v;
    for (int i = 0; i < NUM_REGS; i++) begin
      case (style)
        CFG_ZERO:  v = '0;
        CFG_ONE:   v = 10'd1;
        CFG_BITS:  v = 10'($urandom_range(1));
        CFG_SMALL: v = 10'($urandom_range(3));
        CFG_MID:   v = 10'($urandom_range(12));
        default:   v = CFG_RESET[i];
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= i[2:0];
      cfg_data_i <= v;
      do @(posedge clk_i); while (!cfg_ready_o);
      cfg_q[i] = v;
      cfg_writes++;
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Random ticks: commands are mostly issued when the master is idle, so that whole
  // operations run, and now and then while it is busy, where they must be dropped.
  // The phase always ends with the master idle, ready for reprogramming.
  task automatic run_ticks(input int count, input int mode, input int press);
    owb_in_t t;
    int sent;
    send_gap_pct = (mode == IDLE_SEND) ? 71 : (mode == IDLE_BOTH) ? 18 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 71 : (mode == IDLE_BOTH) ? 18 : 0;
    sent = 0;
    while (sent < count || ph != ST_IDLE) begin
      if (sent == count / 2 && count > 0) begin
        if (press == PRESS_HOLD) hold_left = HOLD_CYCLES;
        if (press == PRESS_PAUSE) drain();
      end
      t.line_level = 1'($urandom_range(1));
      t.data_byte = 8'($urandom);
      t.req_type = REQ_TICK;
      if (sent < count) begin
        if (ph == ST_IDLE) begin
          if ($urandom_range(99) < 70) t.req_type = random_command();
        end else if ($urandom_range(99) < 8) begin
          t.req_type = random_command();
        end
      end
      send_tick(t, 1'b0, '0);
      sent++;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    for (int i = 0; i < NUM_REGS; i++) cfg_q[i] = CFG_RESET[i];
    ph = ST_IDLE;
    op = REQ_TICK;
    tick_cnt = '0;
    bit_idx = '0;
    shreg = '0;
    pres_q = 1'b0;
    rd_q = '0;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table, walked at full rate with no stalls.
    for (int r = 0; r < DIR_ROWS_N; r++) begin
      if (DIR_ROWS[r].setup != CFG_KEEP) begin
        drain();
        program_regs(DIR_ROWS[r].setup);
      end
      send_tick(DIR_ROWS[r].item, DIR_ROWS[r].typed, DIR_ROWS[r].want);
    end
    // Let the last write of the table finish its eight slots.
    run_ticks(0, IDLE_NONE, PRESS_NONE);

    // Random phases over a spread of timings and traffic shapes. The first one holds
    // the result side off long enough to back the block up; the second one lets the
    // block run dry in the middle.
    drain(); program_regs(CFG_SMALL);   run_ticks(160, IDLE_NONE, PRESS_HOLD);
    drain(); program_regs(CFG_SMALL);   run_ticks(160, IDLE_SEND, PRESS_PAUSE);
    drain(); program_regs(CFG_BITS);    run_ticks(160, IDLE_RECV, PRESS_NONE);
    drain(); program_regs(CFG_MID);     run_ticks(160, IDLE_BOTH, PRESS_NONE);
    drain(); program_regs(CFG_SMALL);   run_ticks(120, IDLE_BOTH, PRESS_HOLD);
    drain(); program_regs(CFG_MID);     run_ticks(120, IDLE_SEND, PRESS_NONE);
    drain(); program_regs(CFG_BITS);    run_ticks(100, IDLE_NONE, PRESS_PAUSE);

    drain();
    repeat (4) @(posedge clk_i);

    $display("Summary: %0d ticks taken, %0d bus operations finished, %0d register writes.",
             ticks_taken, ops_finished, cfg_writes);
    $display("Summary: %0d cycles with the input held off, %0d failed checks.",
             stalled_cycles, err_cnt + pending_outputs.size());
    if (err_cnt == 0 && pending_outputs.size() == 0) begin
      $display("[one_wire_bus_master] OK");
    end else begin
      $display("[one_wire_bus_master] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, including the long holds and the
  // heaviest idling.
  initial begin
    #20_000_000;
    $display("Timeout with %0d results still owed.", pending_outputs.size());
    $display("[one_wire_bus_master] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
design/owb_pkg.sv
design/one_wire_bus_master.sv
design/owb_checker.sv
test/tb_top.sv
